// ===== rtl/ovbq_pkg.sv =====
package ovbq_pkg;

    localparam int CAP_W  = 10;
    localparam int CNT_W  = 7;
    localparam int BYTE_W = 8;
    localparam int OP_W   = 3;

    // Operation codes carried in the request.
    localparam logic [OP_W-1:0] OP_PUSH       = 3'd0;
    localparam logic [OP_W-1:0] OP_POP        = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK_OLD   = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK_NEW   = 3'd3;
    localparam logic [OP_W-1:0] OP_DROP       = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

    // Register indexes, taken from paddr[2].
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_STRICT   = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 10'd1023;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] push_byte;
        logic [CNT_W-1:0]  count;
    } t_request;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              byte_valid;
        logic              last;
        logic [CNT_W-1:0]  done_count;
        logic [CAP_W-1:0]  fill_after;
    } t_result;

    // Controller to datapath.
    typedef struct packed {
        logic accept;      // request taken this cycle
        logic single;      // request answers with one result and no bytes
        logic issue;       // read one byte from the ring this cycle
        logic issue_last;  // the byte read this cycle is the final one
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic             multi;  // request is a read that emits bytes
        logic [CNT_W-1:0] len;    // number of bytes it emits
    } t_status;

endpackage

// ===== rtl/overwriting_byte_ring_queue.sv =====
// Channel   Direction  Handshake                          Payload
// --------  ---------  ---------------------------------  ------------------------
// request   in         start high while busy low          i_request (t_request)
// result    out        o_result_valid, one cycle, no hold o_result (t_result)
// config    in/out     APB write: psel, penable, pwrite   pwdata / prdata
//
// A push, drop, clear, unknown operation or a read that emits nothing answers
// with its single result in the cycle after the request and busy stays low, so
// such requests may follow each other in every cycle.
// A pop or peek that emits n bytes holds busy high while they are read; the
// bytes leave one per cycle from the read state, paced by the one registered
// ring read port. The next request is taken while the last byte is out.
// Reset is synchronous and clears the write pointer and fill level, capacity
// returns to 1023 and strict mode to off; the ring store itself is not cleared.
// The receiver cannot stall results, so nothing here waits on the output side.
module overwriting_byte_ring_queue #(
    parameter int STORE_DEPTH  = 1024,
    parameter int MAX_TRANSFER = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ovbq_pkg::t_request  i_request,
    output logic                o_result_valid,
    output ovbq_pkg::t_result   o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ovbq_pkg::*;

    logic [CAP_W-1:0] r_cap;
    logic             r_strict;
    logic             cfg_wr, cap_wr;
    t_cmd             cmd;
    t_status          status;

    // The register index sits at paddr[2]; both registers read back zero-extended to one word.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign cap_wr = cfg_wr & (paddr[2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_RESET;
            r_strict <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_CAPACITY: r_cap    <= pwdata[CAP_W-1:0];
                REG_STRICT:   r_strict <= pwdata[0];
                default:      r_strict <= r_strict;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_CAPACITY: prdata = {22'd0, r_cap};
            REG_STRICT:   prdata = {31'd0, r_strict};
            default:      prdata = '0;
        endcase
    end

    // The controller sequences multi-byte reads; the datapath holds the ring,
    // its pointers and the result registers. A capacity write empties the queue.
    ovbq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    ovbq_dp #(
        .STORE_DEPTH  (STORE_DEPTH),
        .MAX_TRANSFER (MAX_TRANSFER)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_request      (i_request),
        .i_cap          (r_cap),
        .i_strict       (r_strict),
        .i_cap_wr       (cap_wr),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

// ===== rtl/ovbq_ctrl.sv =====
module ovbq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ovbq_pkg::t_status i_status,
    output logic             o_busy,
    output ovbq_pkg::t_cmd   o_cmd
);
    import ovbq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_remain, n_remain;

    always_comb begin
        o_cmd            = '0;
        n_state          = r_state;
        n_remain         = r_remain;
        o_busy           = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_start;
                o_cmd.single = i_start & ~i_status.multi;
                if (i_start && i_status.multi) begin
                    n_state  = S_READ;
                    n_remain = i_status.len;
                end
            end
            S_READ: begin
                o_cmd.issue      = 1'b1;
                o_cmd.issue_last = (r_remain == CNT_W'(1));
                n_remain         = r_remain - CNT_W'(1);
                if (r_remain == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_remain <= '0;
        end else begin
            r_state  <= n_state;
            r_remain <= n_remain;
        end
    end

`ifndef ASSERT_OFF
    a_remain_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_remain != '0))
        else $error("read phase entered with no bytes left");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue_last |=> !o_busy)
        else $error("controller stayed busy after the final byte");
`endif

endmodule

// ===== rtl/ovbq_dp.sv =====
module ovbq_dp #(
    parameter int STORE_DEPTH  = 1024,
    parameter int MAX_TRANSFER = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ovbq_pkg::t_request           i_request,
    input  logic [ovbq_pkg::CAP_W-1:0]   i_cap,
    input  logic                         i_strict,
    input  logic                         i_cap_wr,
    input  ovbq_pkg::t_cmd               i_cmd,
    output ovbq_pkg::t_status            o_status,
    output logic                         o_result_valid,
    output ovbq_pkg::t_result            o_result
);
    import ovbq_pkg::*;

    localparam int AW        = $clog2(STORE_DEPTH);
    localparam int CAP_LIMIT = (STORE_DEPTH - 1 < 1023) ? STORE_DEPTH - 1 : 1023;

    logic [BYTE_W-1:0] r_ring [STORE_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    logic [CAP_W-1:0] r_wp, n_wp;
    logic [CAP_W-1:0] r_fill, n_fill;
    logic [CAP_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_done, n_done;
    logic             r_out_valid, r_byte_valid, r_last;

    logic [CAP_W-1:0] cap_eff;
    logic [CNT_W-1:0] cnt_sat, rd_len, drop_len;
    logic             over, is_read, push_en;
    logic [CAP_W-1:0] back, rd_start, wp_inc, ptr_inc;
    logic [CAP_W:0]   wrap_sum;
    logic [16:0]      wr_wide, rd_wide;
    logic [AW-1:0]    wr_addr, rd_addr;

    always_comb begin
        cap_eff = (i_cap > CAP_W'(CAP_LIMIT)) ? CAP_W'(CAP_LIMIT) : i_cap;
        cnt_sat = (i_request.count > CNT_W'(MAX_TRANSFER)) ? CNT_W'(MAX_TRANSFER)
                                                           : i_request.count;
        // When the request exceeds the fill level, the fill level is below MAX_TRANSFER (64 by default).
        over     = {3'b000, cnt_sat} > r_fill;
        drop_len = over ? r_fill[CNT_W-1:0] : cnt_sat;
        rd_len   = (over && i_strict) ? '0 : drop_len;
        is_read  = (i_request.operation == OP_POP) || (i_request.operation == OP_PEEK_OLD)
                   || (i_request.operation == OP_PEEK_NEW);

        // Peek newest starts rd_len bytes behind the write position, the others
        // start at the oldest byte.
        back     = (i_request.operation == OP_PEEK_NEW) ? {3'b000, rd_len} : r_fill;
        wrap_sum = {1'b0, r_wp} + {1'b0, cap_eff} + (CAP_W+1)'(1) - {1'b0, back};
        rd_start = (r_wp >= back) ? (r_wp - back) : wrap_sum[CAP_W-1:0];

        wp_inc  = (r_wp == cap_eff) ? '0 : r_wp + CAP_W'(1);
        ptr_inc = (r_rd_ptr == cap_eff) ? '0 : r_rd_ptr + CAP_W'(1);

        push_en = i_cmd.accept && (i_request.operation == OP_PUSH) && (cap_eff != '0);

        o_status.multi = is_read && (rd_len != '0);
        o_status.len   = rd_len;

        wr_wide = {7'd0, r_wp};
        rd_wide = {7'd0, r_rd_ptr};
        wr_addr = wr_wide[AW-1:0];
        rd_addr = rd_wide[AW-1:0];
    end

    always_comb begin
        n_wp     = r_wp;
        n_fill   = r_fill;
        n_done   = r_done;
        n_rd_ptr = i_cmd.issue ? ptr_inc : r_rd_ptr;
        if (i_cap_wr) begin
            n_wp   = '0;
            n_fill = '0;
        end else if (i_cmd.accept) begin
            n_done   = '0;
            n_rd_ptr = rd_start;
            case (i_request.operation)
                OP_PUSH: begin
                    if (cap_eff != '0) begin
                        n_wp   = wp_inc;
                        n_done = CNT_W'(1);
                        if (r_fill < cap_eff) begin
                            n_fill = r_fill + CAP_W'(1);
                        end
                    end
                end
                OP_POP: begin
                    n_fill = r_fill - {3'b000, rd_len};
                    n_done = rd_len;
                end
                OP_PEEK_OLD, OP_PEEK_NEW: begin
                    n_done = rd_len;
                end
                OP_DROP: begin
                    n_fill = r_fill - {3'b000, drop_len};
                    n_done = drop_len;
                end
                OP_CLEAR: begin
                    n_wp   = '0;
                    n_fill = '0;
                end
                default: begin
                    n_done = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp         <= '0;
            r_fill       <= '0;
            r_out_valid  <= 1'b0;
            r_byte_valid <= 1'b0;
            r_last       <= 1'b0;
        end else begin
            r_wp         <= n_wp;
            r_fill       <= n_fill;
            r_out_valid  <= i_cmd.single | i_cmd.issue;
            r_byte_valid <= i_cmd.issue;
            r_last       <= i_cmd.single | i_cmd.issue_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_done   <= n_done;
        r_rd_ptr <= n_rd_ptr;
    end

    // Ring store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_ring[wr_addr] <= i_request.push_byte;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_ring[rd_addr];
        end
    end

    assign o_result_valid      = r_out_valid;
    assign o_result.read_byte  = r_byte_valid ? r_rd_data : '0;
    assign o_result.byte_valid = r_byte_valid;
    assign o_result.last       = r_last;
    assign o_result.done_count = r_done;
    assign o_result.fill_after = r_fill;

`ifndef ASSERT_OFF
    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= cap_eff)
        else $error("fill level above capacity");

    a_wp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= cap_eff)
        else $error("write position outside the ring");

    a_byte_from_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_byte_valid) |-> $past(i_cmd.issue))
        else $error("byte result without a ring read");
`endif

endmodule

// ===== verif/tb_overwriting_byte_ring_queue.sv =====
module tb_overwriting_byte_ring_queue;
    import ovbq_pkg::*;

    // Block parameters, kept at the values the design uses by default.
    localparam int RING_DEPTH = 1024;
    localparam int MAX_XFER   = 64;

    // Operation codes the block has no meaning for. It must answer them with
    // a single empty result and leave the queue alone.
    localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

    // Run guard. The slowest legal run is far below this, even with every request
    // emitting 64 bytes, plus idle gaps and register writes.
    localparam int CYCLE_LIMIT  = 300000;
    // Quiet cycles before a register write and at the end of the run.
    localparam int SETTLE_WAIT  = 4;
    localparam int DRAIN_CYCLES = 8;

    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 30;
    localparam int N_ROWS          = 28;

    typedef enum logic {ROW_REQUEST, ROW_REGISTER} t_row_kind;

    // One line of the directed table. A register row writes reg_value to the
    // register selected by reg_sel. A request row sends req; when fixed is set,
    // its single empty result is given here by done count and fill level.
    // Otherwise the ring predictor works out what the request must produce.
    typedef struct packed {
        t_row_kind        kind;
        logic             reg_sel;
        logic [31:0]      reg_value;
        t_request         req;
        logic             fixed;
        logic [CNT_W-1:0] exp_done;
        logic [CAP_W-1:0] exp_fill;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_request    i_request = '0;
    logic        o_result_valid;
    t_result     o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // The predictor's own copy of the queue state and its two settings.
    logic [BYTE_W-1:0] ring_copy [RING_DEPTH];
    int unsigned       copy_wr_pos = 0;
    int unsigned       copy_fill = 0;
    int unsigned       copy_cap = CAP_RESET;
    logic              copy_strict = 1'b0;

    // Results still owed by the block, oldest first.
    t_result awaited_results [$];

    int error_count = 0;
    int cycle_count = 0;

    t_stim_row directed_rows [N_ROWS];

    overwriting_byte_ring_queue #(
        .STORE_DEPTH  (RING_DEPTH),
        .MAX_TRANSFER (MAX_XFER)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_request      (i_request),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or never answers a request.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Works out the results of one request and advances the copied state.
    // With record low the state moves but nothing is queued; the directed table
    // uses that when it supplies the expected result itself.
    task automatic ring_predict(input t_request req, input logic record);
        int unsigned usable_cap;
        int unsigned slots;
        int unsigned n_bytes;
        int unsigned first;
        int unsigned done;
        logic        emits;
        logic [BYTE_W-1:0] picked [MAX_XFER];
        t_result     res;

        usable_cap = (copy_cap < RING_DEPTH - 1) ? copy_cap : RING_DEPTH - 1;
        slots = usable_cap + 1;
        n_bytes = (req.count > MAX_XFER) ? MAX_XFER : req.count;
        done = 0;
        emits = 1'b0;
        if (copy_wr_pos >= slots) begin
            copy_wr_pos = 0;
        end
        if (copy_fill > usable_cap) begin
            copy_fill = usable_cap;
        end

        case (req.operation)
            OP_PUSH: begin
                // With no usable room the byte is simply lost.
                if (usable_cap > 0) begin
                    ring_copy[copy_wr_pos] = req.push_byte;
                    copy_wr_pos = (copy_wr_pos + 1) % slots;
                    if (copy_fill < usable_cap) begin
                        copy_fill++;
                    end
                    done = 1;
                end
            end
            OP_POP, OP_PEEK_OLD, OP_PEEK_NEW: begin
                // Strict mode refuses an oversized read outright; otherwise it
                // is cut down to what the queue holds.
                if (copy_strict && n_bytes > copy_fill) begin
                    n_bytes = 0;
                end
                if (n_bytes > copy_fill) begin
                    n_bytes = copy_fill;
                end
                // Peek newest starts n bytes behind the write position, but the
                // bytes still come out oldest first.
                first = (copy_wr_pos + slots -
                         ((req.operation == OP_PEEK_NEW) ? n_bytes : copy_fill)) % slots;
                for (int k = 0; k < n_bytes; k++) begin
                    picked[k] = ring_copy[(first + k) % slots];
                end
                if (req.operation == OP_POP) begin
                    copy_fill -= n_bytes;
                end
                done = n_bytes;
                emits = (n_bytes != 0);
            end
            OP_DROP: begin
                // Drop never refuses, even in strict mode.
                done = (n_bytes < copy_fill) ? n_bytes : copy_fill;
                copy_fill -= done;
            end
            OP_CLEAR: begin
                copy_wr_pos = 0;
                copy_fill = 0;
            end
            default: begin
            end
        endcase

        if (record) begin
            res = '0;
            res.done_count = CNT_W'(done);
            res.fill_after = CAP_W'(copy_fill);
            if (!emits) begin
                res.last = 1'b1;
                awaited_results.push_back(res);
            end else begin
                for (int k = 0; k < n_bytes; k++) begin
                    res.read_byte = picked[k];
                    res.byte_valid = 1'b1;
                    res.last = (k == n_bytes - 1);
                    awaited_results.push_back(res);
                end
            end
        end
    endtask

    // Presents a request, after a random idle gap, and returns at the clock edge
    // that accepts it. Start is left high so that back-to-back requests never
    // see it drop; only the gap loop, settle_block or the end of the run lowers it.
    task automatic send_request(input t_request req, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_request <= req;
        do @(posedge i_clk); while (busy);
    endtask

    // Brings the block to rest: no request pending, every result delivered,
    // and then a quiet wait for anything still in flight.
    task automatic settle_block();
        start <= 1'b0;
        while (awaited_results.size() != 0 || busy) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // A two-phase write on the configuration port. The predictor copies the
    // setting at the edge that completes the access. Writing the capacity
    // empties the queue, so the copy is emptied too.
    task automatic write_register(input logic sel, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {1'b0, sel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == REG_CAPACITY) begin
            copy_cap = value[CAP_W-1:0];
            copy_wr_pos = 0;
            copy_fill = 0;
        end else begin
            copy_strict = value[0];
        end
        @(posedge i_clk);
    endtask

    function automatic t_stim_row req_row(input logic [OP_W-1:0] op,
                                          input logic [BYTE_W-1:0] data,
                                          input logic [CNT_W-1:0] cnt,
                                          input logic fixed,
                                          input logic [CNT_W-1:0] done,
                                          input logic [CAP_W-1:0] fill);
        t_stim_row row;
        row = '0;
        row.kind = ROW_REQUEST;
        row.req.operation = op;
        row.req.push_byte = data;
        row.req.count = cnt;
        row.fixed = fixed;
        row.exp_done = done;
        row.exp_fill = fill;
        return row;
    endfunction

    function automatic t_stim_row reg_row(input logic sel, input logic [31:0] value);
        t_stim_row row;
        row = '0;
        row.kind = ROW_REGISTER;
        row.reg_sel = sel;
        row.reg_value = value;
        return row;
    endfunction

    // Random traffic leans on pushes so the queue actually fills and wraps.
    // Counts are mostly small, with an occasional one anywhere in the field,
    // including values above the transfer limit.
    function automatic t_request random_request();
        t_request    req;
        int unsigned pick;
        pick = $urandom_range(99);
        req.push_byte = BYTE_W'($urandom_range(255));
        req.count = ($urandom_range(9) == 0) ? CNT_W'($urandom_range(127))
                                             : CNT_W'($urandom_range(10));
        if (pick < 45) begin
            req.operation = OP_PUSH;
        end else if (pick < 60) begin
            req.operation = OP_POP;
        end else if (pick < 70) begin
            req.operation = OP_PEEK_OLD;
        end else if (pick < 80) begin
            req.operation = OP_PEEK_NEW;
        end else if (pick < 88) begin
            req.operation = OP_DROP;
        end else if (pick < 92) begin
            req.operation = OP_CLEAR;
        end else if (pick < 96) begin
            req.operation = OP_UNUSED_A;
        end else begin
            req.operation = OP_UNUSED_B;
        end
        return req;
    endfunction

    // Result checker. The block cannot be stalled, so every strobe is taken
    // at the edge that ends its cycle and matched against the oldest entry
    // still owed.
    always @(posedge i_clk) begin : check_result
        t_result want;
        if (i_rst_n && o_result_valid) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: read_byte %0d, done_count %0d, fill_after %0d",
                       o_result.read_byte, o_result.done_count, o_result.fill_after);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_result.read_byte !== want.read_byte) begin
                    $error("read_byte: expected %0d, got %0d",
                           want.read_byte, o_result.read_byte);
                    error_count++;
                end
                if (o_result.byte_valid !== want.byte_valid) begin
                    $error("byte_valid: expected %0d, got %0d",
                           want.byte_valid, o_result.byte_valid);
                    error_count++;
                end
                if (o_result.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_result.last);
                    error_count++;
                end
                if (o_result.done_count !== want.done_count) begin
                    $error("done_count: expected %0d, got %0d",
                           want.done_count, o_result.done_count);
                    error_count++;
                end
                if (o_result.fill_after !== want.fill_after) begin
                    $error("fill_after: expected %0d, got %0d",
                           want.fill_after, o_result.fill_after);
                    error_count++;
                end
            end
        end
    end

    initial begin
        t_request    req;
        t_result     typed_res;
        int          counted;
        int unsigned cap_plan [N_PHASES];
        logic        strict_plan [N_PHASES];
        int          idle_plan [4];

        // Directed part. It starts from the reset settings (capacity 1023,
        // strict mode off) and walks the empty queue, the reserved codes, field
        // extremes, clipping, drop and clear, a zero capacity, then a tiny
        // strict queue that overwrites and refuses oversized reads.
        directed_rows = '{
            req_row(OP_POP,      8'h00, 7'd5,   1'b1, 7'd0, 10'd0),
            req_row(OP_PEEK_NEW, 8'h00, 7'd64,  1'b1, 7'd0, 10'd0),
            req_row(OP_UNUSED_A, 8'h00, 7'd0,   1'b1, 7'd0, 10'd0),
            req_row(OP_UNUSED_B, 8'hFF, 7'd127, 1'b1, 7'd0, 10'd0),
            req_row(OP_PUSH,     8'h00, 7'd0,   1'b1, 7'd1, 10'd1),
            req_row(OP_PUSH,     8'hFF, 7'd127, 1'b1, 7'd1, 10'd2),
            req_row(OP_PUSH,     8'hA5, 7'd3,   1'b1, 7'd1, 10'd3),
            req_row(OP_PUSH,     8'h5A, 7'd0,   1'b1, 7'd1, 10'd4),
            req_row(OP_PEEK_OLD, 8'h00, 7'd127, 1'b0, 7'd0, 10'd0),
            req_row(OP_PEEK_NEW, 8'h00, 7'd2,   1'b0, 7'd0, 10'd0),
            req_row(OP_POP,      8'h00, 7'd0,   1'b1, 7'd0, 10'd4),
            req_row(OP_POP,      8'h00, 7'd1,   1'b0, 7'd0, 10'd0),
            req_row(OP_DROP,     8'h00, 7'd127, 1'b1, 7'd3, 10'd0),
            req_row(OP_PUSH,     8'h81, 7'd0,   1'b1, 7'd1, 10'd1),
            req_row(OP_CLEAR,    8'h00, 7'd0,   1'b1, 7'd0, 10'd0),
            reg_row(REG_CAPACITY, 32'd0),
            req_row(OP_PUSH,     8'h7E, 7'd0,   1'b1, 7'd0, 10'd0),
            req_row(OP_POP,      8'h00, 7'd64,  1'b1, 7'd0, 10'd0),
            reg_row(REG_CAPACITY, 32'd3),
            reg_row(REG_STRICT,   32'd1),
            req_row(OP_PUSH,     8'h11, 7'd0,   1'b1, 7'd1, 10'd1),
            req_row(OP_PUSH,     8'h22, 7'd0,   1'b1, 7'd1, 10'd2),
            req_row(OP_PUSH,     8'h33, 7'd0,   1'b1, 7'd1, 10'd3),
            req_row(OP_PUSH,     8'h44, 7'd0,   1'b1, 7'd1, 10'd3),
            req_row(OP_PEEK_OLD, 8'h00, 7'd4,   1'b1, 7'd0, 10'd3),
            req_row(OP_POP,      8'h00, 7'd4,   1'b1, 7'd0, 10'd3),
            req_row(OP_PEEK_NEW, 8'h00, 7'd3,   1'b0, 7'd0, 10'd0),
            req_row(OP_DROP,     8'h00, 7'd64,  1'b1, 7'd3, 10'd0)
        };

        // Random phases: capacity and strict setting per phase, extremes
        // included. The idle plan cycles through no gaps, heavy gaps, no gaps
        // and light gaps on the request side.
        cap_plan    = '{1023, 7, 1, 0, 64, 1023, 3, 300};
        strict_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        idle_plan   = '{0, 57, 0, 23};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_REGISTER) begin
                settle_block();
                write_register(directed_rows[r].reg_sel, directed_rows[r].reg_value);
            end else begin
                send_request(directed_rows[r].req, 0);
                if (directed_rows[r].fixed) begin
                    ring_predict(directed_rows[r].req, 1'b0);
                    typed_res = '0;
                    typed_res.last = 1'b1;
                    typed_res.done_count = directed_rows[r].exp_done;
                    typed_res.fill_after = directed_rows[r].exp_fill;
                    awaited_results.push_back(typed_res);
                end else begin
                    ring_predict(directed_rows[r].req, 1'b1);
                end
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle_block();
            write_register(REG_CAPACITY, 32'(cap_plan[ph]));
            write_register(REG_STRICT, 32'(strict_plan[ph]));
            counted = 0;
            // Requests with a reserved code are sent but not counted, since
            // the block does nothing with them.
            while (counted < ITEMS_PER_PHASE) begin
                req = random_request();
                if (req.operation != OP_UNUSED_A && req.operation != OP_UNUSED_B) begin
                    counted++;
                end
                send_request(req, idle_plan[ph % 4]);
                ring_predict(req, 1'b1);
            end
        end

        start <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ovbq_pkg.sv
rtl/ovbq_ctrl.sv
rtl/ovbq_dp.sv
rtl/overwriting_byte_ring_queue.sv
verif/tb_overwriting_byte_ring_queue.sv
